// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/utfd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, constants and range checks of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utfd_pkg;

    localparam int CP_BITS            = 21;
    localparam int CHAR_COUNT_BITS    = 16;
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 4;
    localparam int QUEUE_PTR_BITS     = $clog2(QUEUE_DEPTH);

    // What closes a command after its run of bad results.
    typedef logic [1:0] tail_t;
    localparam tail_t TAIL_NONE  = 2'd0;
    localparam tail_t TAIL_VALUE = 2'd1;
    localparam tail_t TAIL_BAD   = 2'd2;
    localparam tail_t TAIL_EOS   = 2'd3;

    typedef logic [CP_BITS-1:0] cp_t;

    // One command from the front to the back: a run of bad results,
    // then an optional closing result.
    typedef struct packed {
        logic [2:0] bad_run;
        tail_t      tail;
        cp_t        code_point;
    } cmd_t;

    // Range and surrogate checks of a completed multi-byte form.
    function automatic logic value_ok(input logic [2:0] len, input cp_t v);
        logic ok;
        ok = 1'b0;
        unique case (len)
            3'd2:    ok = (v >= 21'h80) && (v <= 21'h7FF);
            3'd3:    ok = (v >= 21'h800) && (v <= 21'hFFFD) &&
                          (v != 21'hD800) && (v != 21'hDB7F) &&
                          (v != 21'hDB80) && (v != 21'hDBFF) &&
                          (v != 21'hDC00) && (v != 21'hDF80) &&
                          (v != 21'hDFFF);
            3'd4:    ok = (v >= 21'h10000) && (v <= 21'h10FFFF);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// File: sv/utfd_front.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the pending multi-byte form and issues commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utfd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      byte_in,
    output logic            push,
    output utfd_pkg::cmd_t  cmd
);
    import utfd_pkg::*;

    logic [2:0] seq_len_reg, seq_len_next;
    logic [2:0] taken_reg, taken_next;
    cp_t        acc_reg, acc_next;

    tail_t      fresh_tail;
    logic [2:0] fresh_len;
    cp_t        fresh_acc;
    logic [2:0] new_taken;
    cp_t        acc_shift;
    logic       is_cont;

    // Handling of a byte when no form is pending.
    always_comb
    begin
        fresh_tail = TAIL_NONE;
        fresh_len  = 3'd0;
        fresh_acc  = '0;
        priority if (byte_in == 8'h00)
        begin
            fresh_tail = TAIL_EOS;
        end
        else if (byte_in < 8'h80)
        begin
            fresh_tail = TAIL_VALUE;
        end
        else if (byte_in < 8'hC0)
        begin
            fresh_tail = TAIL_BAD;
        end
        else if (byte_in < 8'hE0)
        begin
            fresh_len = 3'd2;
            fresh_acc = cp_t'(byte_in[4:0]);
        end
        else if (byte_in < 8'hF0)
        begin
            fresh_len = 3'd3;
            fresh_acc = cp_t'(byte_in[3:0]);
        end
        else if (byte_in < 8'hF8)
        begin
            fresh_len = 3'd4;
            fresh_acc = cp_t'(byte_in[2:0]);
        end
        else if (byte_in < 8'hFC)
        begin
            fresh_len = 3'd5;
        end
        else
        begin
            fresh_len = 3'd6;
        end
    end

    assign is_cont   = (byte_in[7:6] == 2'b10);
    assign new_taken = taken_reg + 3'd1;
    // Obsolete five- and six-byte forms gather no bits.
    assign acc_shift = (seq_len_reg <= 3'd4) ? {acc_reg[CP_BITS-7:0], byte_in[5:0]} : acc_reg;

    always_comb
    begin
        seq_len_next   = fresh_len;
        taken_next     = 3'd0;
        acc_next       = fresh_acc;
        cmd.bad_run    = 3'd0;
        cmd.tail       = fresh_tail;
        cmd.code_point = (fresh_tail == TAIL_VALUE) ? cp_t'(byte_in) : '0;
        if (seq_len_reg != 3'd0)
        begin
            if (is_cont)
            begin
                if ({1'b0, new_taken} + 4'd1 >= {1'b0, seq_len_reg})
                begin
                    seq_len_next = 3'd0;
                    acc_next     = '0;
                    if (value_ok(seq_len_reg, acc_shift))
                    begin
                        cmd.tail       = TAIL_VALUE;
                        cmd.code_point = acc_shift;
                    end
                    else
                    begin
                        cmd.tail       = TAIL_BAD;
                        cmd.code_point = '0;
                    end
                end
                else
                begin
                    seq_len_next   = seq_len_reg;
                    taken_next     = new_taken;
                    acc_next       = acc_shift;
                    cmd.tail       = TAIL_NONE;
                    cmd.code_point = '0;
                end
            end
            else
            begin
                // Cut short: bad for the lead and each continuation taken,
                // then the byte starts over.
                cmd.bad_run = taken_reg + 3'd1;
            end
        end
    end

    assign push = accept && ((cmd.bad_run != 3'd0) || (cmd.tail != TAIL_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= 3'd0;
            taken_reg   <= 3'd0;
            acc_reg     <= '0;
        end
        else if (accept)
        begin
            seq_len_reg <= seq_len_next;
            taken_reg   <= taken_next;
            acc_reg     <= acc_next;
        end
    end

    `ASSERT_ALWAYS(a_taken_below_len, clk, rst_n,
        (seq_len_reg == 3'd0 && taken_reg == 3'd0) || (taken_reg + 3'd1 < seq_len_reg),
        "front: continuation count out of step with form length")

endmodule

// File: sv/utfd_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder command queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utfd_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  utfd_pkg::cmd_t  wdata,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output utfd_pkg::cmd_t  rdata
);
    import utfd_pkg::*;

    cmd_t                    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    assign full      = (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `ASSERT_NEVER(a_no_push_full, clk, rst_n, push && full,
        "queue: write while full")
    `ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && !not_empty,
        "queue: read while empty")

endmodule

// File: sv/utfd_back.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Expands commands into results, keeps the character count, drives output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utfd_back
#(
    parameter int COUNT_BITS = utfd_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               not_empty,
    input  utfd_pkg::cmd_t                     head,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output utfd_pkg::cp_t                      out_code_point,
    output logic                               out_bad,
    output logic                               out_eos,
    output logic [utfd_pkg::CHAR_COUNT_BITS-1:0] out_char_count,
    output logic                               out_last
);
    import utfd_pkg::*;

    logic [COUNT_BITS-1:0]      counter_reg, counter_next;
    logic [2:0]                 idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    cp_t                        cp_reg, cp_next;
    logic                       bad_reg, bad_next;
    logic                       eos_reg, eos_next;
    logic [CHAR_COUNT_BITS-1:0] count_out_reg, count_out_next;
    logic                       last_reg, last_next;

    logic                       advance;
    logic                       emit;
    logic [2:0]                 n_results;
    logic                       is_last;
    logic [COUNT_BITS-1:0]      counter_inc;
    logic [COUNT_BITS+CHAR_COUNT_BITS-1:0] inc_wide, cur_wide;

    assign advance     = !valid_reg || out_ready;
    assign emit        = advance && not_empty;
    assign n_results   = head.bad_run + ((head.tail != TAIL_NONE) ? 3'd1 : 3'd0);
    assign is_last     = (idx_reg + 3'd1 == n_results);
    assign pop         = emit && is_last;
    assign counter_inc = (counter_reg == '1) ? counter_reg : counter_reg + 1'b1;
    assign inc_wide    = {{CHAR_COUNT_BITS{1'b0}}, counter_inc};
    assign cur_wide    = {{CHAR_COUNT_BITS{1'b0}}, counter_reg};

    always_comb
    begin
        counter_next   = counter_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg && !out_ready;
        cp_next        = cp_reg;
        bad_next       = bad_reg;
        eos_next       = eos_reg;
        count_out_next = count_out_reg;
        last_next      = last_reg;
        if (emit)
        begin
            valid_next     = 1'b1;
            last_next      = is_last;
            idx_next       = is_last ? 3'd0 : idx_reg + 3'd1;
            cp_next        = '0;
            bad_next       = 1'b1;
            eos_next       = 1'b0;
            counter_next   = counter_inc;
            count_out_next = inc_wide[CHAR_COUNT_BITS-1:0];
            if (idx_reg >= head.bad_run)
            begin
                unique case (head.tail)
                    TAIL_VALUE:
                    begin
                        cp_next  = head.code_point;
                        bad_next = 1'b0;
                    end
                    TAIL_EOS:
                    begin
                        bad_next       = 1'b0;
                        eos_next       = 1'b1;
                        counter_next   = '0;
                        count_out_next = cur_wide[CHAR_COUNT_BITS-1:0];
                    end
                    default:
                    begin
                        bad_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg        <= cp_next;
        bad_reg       <= bad_next;
        eos_reg       <= eos_next;
        count_out_reg <= count_out_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            idx_reg     <= 3'd0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            counter_reg <= counter_next;
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
        end
    end

    assign out_valid      = valid_reg;
    assign out_code_point = cp_reg;
    assign out_bad        = bad_reg;
    assign out_eos        = eos_reg;
    assign out_char_count = count_out_reg;
    assign out_last       = last_reg;

    `ASSERT_ALWAYS(a_idx_in_cmd, clk, rst_n,
        !not_empty || (idx_reg < n_results),
        "back: result index beyond the command")
    `ASSERT_ALWAYS(a_eos_clean, clk, rst_n,
        !(valid_reg && eos_reg) || (!bad_reg && cp_reg == '0 && last_reg),
        "back: terminator result carries data or is not last")

endmodule

// File: sv/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream into code points with a per-string character count.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  s_tdata[7:0] = byte_in
//  m_*       out  m_tvalid/m_tready  m_tdata = code_point, char_count;
//                                    m_tuser = bad, end_of_string; m_tlast = last
//
//  Cycles: one byte is accepted per cycle while the command queue has room.
//  Each result leaves the output register one per cycle unless m_tready
//  stalls, after the byte's command is registered in the queue.
//  A truncated form produces up to six results from one command; the
//  front keeps taking bytes until the four-entry queue fills.
//  Reset: rst_n clears the decoder state, the queue and the count at once.
//  Stalls on m_tready hold the output register and back up into the queue.
//
// The front end holds the pending multi-byte form (its length, the number of
// continuation bytes taken and the bits gathered so far) and turns each byte
// into at most one command: a run of bad results for a form that was cut
// short, followed by an optional closing result (a code point, a bad result
// or a string terminator). Bytes that only extend a form issue no command.
// The back end steps through each command one result per cycle while
// m_tready does not stall it, keeps the saturating character counter and
// marks the final result of each byte with tlast.
module utf8_stream_decoder
#(
    parameter int COUNT_BITS = utfd_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [20:0] code_point, [36:21] char_count, [39:37] zero
    output logic [1:0]  m_tuser,   // [0] bad, [1] end_of_string
    output logic        m_tlast    // last result caused by an input byte
);
    import utfd_pkg::*;

    logic                       accept;
    logic                       push;
    logic                       full;
    logic                       pop;
    logic                       not_empty;
    cmd_t                       cmd;
    cmd_t                       head;
    cp_t                        code_point;
    logic                       bad;
    logic                       eos;
    logic [CHAR_COUNT_BITS-1:0] char_count;

    // A byte is taken whenever the queue can hold the command it may cause.
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    utfd_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (s_tdata),
        .push    (push),
        .cmd     (cmd)
    );

    utfd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .rdata     (head)
    );

    utfd_back
    #(
        .COUNT_BITS (COUNT_BITS)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .not_empty      (not_empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_code_point (code_point),
        .out_bad        (bad),
        .out_eos        (eos),
        .out_char_count (char_count),
        .out_last       (m_tlast)
    );

    assign m_tdata = {3'b000, char_count, code_point};
    assign m_tuser = {eos, bad};

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Sends directed and random byte streams with random gaps on both stream
// sides, and checks every result item against a built-in decoder.
// ----------------------------------------------------------------------------
module tb_top;

    import utfd_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int          RESET_CYCLES = 12;
    localparam int          RANDOM_BYTES = 128;
    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    localparam logic [COUNT_BITS_DEFAULT-1:0] COUNT_TOP = '1;

    // One expected result item.
    typedef struct {
        cp_t                        code_point;
        logic                       bad;
        logic                       eos;
        logic [CHAR_COUNT_BITS-1:0] count;
        logic                       is_last;
    } decoded_t;

    // Decoder state mirror and the queue of results still to come.
    class utf8_scoreboard;
        logic [2:0]                    form_len;
        logic [2:0]                    conts_taken;
        cp_t                           gathered;
        logic [COUNT_BITS_DEFAULT-1:0] chars;
        decoded_t                      pending_q[$];
        int unsigned                   errors;

        function new();
            form_len    = '0;
            conts_taken = '0;
            gathered    = '0;
            chars       = '0;
            errors      = 0;
        endfunction

        function void clear_form();
            form_len    = '0;
            conts_taken = '0;
            gathered    = '0;
        endfunction

        function void bump_chars();
            if (chars != COUNT_TOP)
                chars++;
        endfunction

        function void add_result(cp_t cp, logic bad, logic eos);
            decoded_t r;
            r.code_point = cp;
            r.bad        = bad;
            r.eos        = eos;
            r.count      = chars[CHAR_COUNT_BITS-1:0];
            r.is_last    = 1'b0;
            pending_q.push_back(r);
        endfunction

        // Range rules of completed two-, three- and four-byte forms.
        function bit form_ok(logic [2:0] len, cp_t v);
            bit ok;
            ok = 1'b0;
            if (len == 3'd2)
                ok = v >= 21'h80 && v <= 21'h7FF;
            else if (len == 3'd3)
                ok = v >= 21'h800 && v <= 21'hFFFD &&
                     !(v inside {21'hD800, 21'hDB7F, 21'hDB80, 21'hDBFF,
                                 21'hDC00, 21'hDF80, 21'hDFFF});
            else if (len == 3'd4)
                ok = v >= 21'h10000 && v <= 21'h10FFFF;
            return ok;
        endfunction

        // A byte seen with no form pending.
        function void take_fresh_byte(logic [7:0] b);
            if (b == 8'h00)
            begin
                add_result('0, 1'b0, 1'b1);
                chars = '0;
            end
            else if (b < 8'h80)
            begin
                bump_chars();
                add_result(cp_t'(b), 1'b0, 1'b0);
            end
            else if (b < 8'hC0)
            begin
                bump_chars();
                add_result('0, 1'b1, 1'b0);
            end
            else
            begin
                conts_taken = '0;
                gathered    = '0;
                if (b < 8'hE0)
                begin
                    form_len = 3'd2;
                    gathered = cp_t'(b[4:0]);
                end
                else if (b < 8'hF0)
                begin
                    form_len = 3'd3;
                    gathered = cp_t'(b[3:0]);
                end
                else if (b < 8'hF8)
                begin
                    form_len = 3'd4;
                    gathered = cp_t'(b[2:0]);
                end
                else if (b < 8'hFC)
                    form_len = 3'd5;
                else
                    form_len = 3'd6;
            end
        endfunction

        // Works out the results of one accepted input item.
        function void note_byte(logic [7:0] b);
            int unsigned queued;
            int unsigned cut_conts;
            queued = pending_q.size();
            if (form_len == 3'd0)
                take_fresh_byte(b);
            else if (b[7:6] == 2'b10)
            begin
                // Obsolete five- and six-byte forms only count their bytes.
                if (form_len <= 3'd4)
                    gathered = {gathered[CP_BITS-7:0], b[5:0]};
                conts_taken++;
                if (conts_taken + 1 >= form_len)
                begin
                    bump_chars();
                    if (form_ok(form_len, gathered))
                        add_result(gathered, 1'b0, 1'b0);
                    else
                        add_result('0, 1'b1, 1'b0);
                    clear_form();
                end
            end
            else
            begin
                // Cut short: one bad item for the lead and one per taken
                // continuation, then the cutting byte starts over.
                cut_conts = conts_taken;
                bump_chars();
                add_result('0, 1'b1, 1'b0);
                repeat (cut_conts)
                begin
                    bump_chars();
                    add_result('0, 1'b1, 1'b0);
                end
                clear_form();
                take_fresh_byte(b);
            end
            if (pending_q.size() > queued)
                pending_q[pending_q.size()-1].is_last = 1'b1;
        endfunction

        function void check_result(cp_t cp, logic [CHAR_COUNT_BITS-1:0] count,
                                   logic bad, logic eos, logic is_last);
            decoded_t e;
            if (pending_q.size() == 0)
            begin
                $error("result item arrived with none expected");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (cp !== e.code_point)
            begin
                $error("code_point: expected %h, actual %h", e.code_point, cp);
                errors++;
            end
            if (bad !== e.bad)
            begin
                $error("bad: expected %b, actual %b", e.bad, bad);
                errors++;
            end
            if (eos !== e.eos)
            begin
                $error("end_of_string: expected %b, actual %b", e.eos, eos);
                errors++;
            end
            if (count !== e.count)
            begin
                $error("char_count: expected %0d, actual %0d", e.count, count);
                errors++;
            end
            if (is_last !== e.is_last)
            begin
                $error("last: expected %b, actual %b", e.is_last, is_last);
                errors++;
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    utf8_scoreboard sb;
    logic [7:0]     stream_q[$];
    bit             send_idle_on = 1'b0;
    bit             recv_idle_on = 1'b0;
    int unsigned    cycle_count  = 0;

    // Directed opening: ASCII extremes, a terminator, the edges of the
    // two- and four-byte ranges, a stray continuation, a surrogate, both
    // obsolete forms, a cut with four continuations taken (six results),
    // a cut by the terminator and a lone lead cut by ASCII.
    localparam logic [7:0] DIRECTED_BYTES [28] = '{
        8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'h80, 8'hED, 8'hA0, 8'h80, 8'hF8, 8'hBF, 8'hBF, 8'hBF,
        8'hBF, 8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h41, 8'hE2,
        8'h82, 8'h00, 8'hFF, 8'h41
    };

    localparam cp_t EDGE3 [11] = '{
        21'hD800, 21'hDB7F, 21'hDB80, 21'hDBFF, 21'hDC00, 21'hDF80,
        21'hDFFF, 21'hFFFE, 21'hFFFF, 21'hFFFD, 21'h800
    };

    utf8_stream_decoder #(
        .COUNT_BITS (COUNT_BITS_DEFAULT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Picks a value for a form of the given length: mostly legal, with the
    // range edges, the rejected values and overlong encodings mixed in.
    function automatic cp_t pick_value(int len);
        int  sel;
        cp_t v;
        sel = $urandom_range(0, 9);
        v   = '0;
        if (len == 2)
        begin
            if (sel < 7)       v = cp_t'($urandom_range(21'h80, 21'h7FF));
            else if (sel == 7) v = $urandom_range(0, 1) ? 21'h80 : 21'h7FF;
            else if (sel == 8) v = cp_t'($urandom_range(0, 21'h7F));
            else               v = cp_t'($urandom_range(0, 21'h7FF));
        end
        else if (len == 3)
        begin
            if (sel < 6)       v = cp_t'($urandom_range(21'h800, 21'hFFFD));
            else if (sel < 8)  v = EDGE3[$urandom_range(0, 10)];
            else if (sel == 8) v = cp_t'($urandom_range(0, 21'hFFFF));
            else               v = cp_t'($urandom_range(0, 21'h7FF));
        end
        else
        begin
            if (sel < 7)       v = cp_t'($urandom_range(21'h10000, 21'h10FFFF));
            else if (sel == 7) v = $urandom_range(0, 1) ? 21'h10000 : 21'h10FFFF;
            else if (sel == 8) v = cp_t'($urandom_range(21'h110000, 21'h1FFFFF));
            else               v = cp_t'($urandom_range(0, 21'hFFFF));
        end
        return v;
    endfunction

    // Queues the bytes of a value encoded with the given length.
    function automatic void queue_form(int len, cp_t v);
        logic [7:0] lead;
        lead = (len == 2) ? 8'hC0 : (len == 3) ? 8'hE0 : 8'hF0;
        stream_q.push_back(lead | 8'(v >> (6 * (len - 1))));
        for (int k = len - 2; k >= 0; k--)
            stream_q.push_back(8'h80 | 8'((v >> (6 * k)) & 21'h3F));
    endfunction

    function automatic logic [7:0] random_cont();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // Queues one random unit: mostly well-formed characters, the rest
    // obsolete forms, cut forms, strays, terminators and raw noise.
    function automatic void queue_random_unit();
        int         sel;
        int         len;
        int         conts;
        logic [7:0] cutter;
        sel = $urandom_range(0, 99);
        if (sel < 55)
        begin
            len = $urandom_range(1, 4);
            if (len == 1)
                stream_q.push_back(8'($urandom_range(1, 8'h7F)));
            else
                queue_form(len, pick_value(len));
        end
        else if (sel < 63)
        begin
            len = $urandom_range(5, 6);
            stream_q.push_back(len == 5 ? 8'($urandom_range(8'hF8, 8'hFB))
                                        : 8'($urandom_range(8'hFC, 8'hFF)));
            repeat (len - 1) stream_q.push_back(random_cont());
        end
        else if (sel < 75)
        begin
            len   = $urandom_range(2, 6);
            conts = $urandom_range(0, len - 2);
            case (len)
                2:       stream_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                3:       stream_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                4:       stream_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                5:       stream_q.push_back(8'($urandom_range(8'hF8, 8'hFB)));
                default: stream_q.push_back(8'($urandom_range(8'hFC, 8'hFF)));
            endcase
            repeat (conts) stream_q.push_back(random_cont());
            case ($urandom_range(0, 2))
                0:       cutter = 8'h00;
                1:       cutter = 8'($urandom_range(1, 8'h7F));
                default: cutter = 8'($urandom_range(8'hC0, 8'hFF));
            endcase
            stream_q.push_back(cutter);
        end
        else if (sel < 81)
            stream_q.push_back(random_cont());
        else if (sel < 90)
            stream_q.push_back(8'h00);
        else
            stream_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Offers one byte and waits until the decoder takes it.
    task automatic send_byte(logic [7:0] b);
        if (send_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_byte(b);
    endtask

    task automatic send_queued();
        while (stream_q.size() != 0)
            send_byte(stream_q.pop_front());
    endtask

    // Result side: checks each accepted item, then decides whether the
    // next cycle stalls.
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata[20:0], m_tdata[36:21], m_tuser[0],
                                m_tuser[1], m_tlast);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (recv_idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        foreach (DIRECTED_BYTES[i])
            stream_q.push_back(DIRECTED_BYTES[i]);
        send_queued();

        // Random part in four stretches: gaps on both sides, on the sending
        // side only, on the result side only, and none.
        for (int part = 0; part < 4; part++)
        begin
            send_idle_on = (part == 0 || part == 1);
            recv_idle_on = (part == 0 || part == 2);
            while (stream_q.size() < RANDOM_BYTES / 4)
                queue_random_unit();
            send_queued();
        end

        // A short closing string with no gaps: a three-byte character, a
        // stray continuation, its terminator, then a short string after
        // the clear.
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        stream_q.push_back(8'h00);
        queue_form(3, pick_value(3));
        stream_q.push_back(8'h80);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h41);
        stream_q.push_back(8'h00);
        send_queued();
        s_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
